FILE: src/min_tracking_stack_macros.svh
// assertion macros shared by the min tracking stack rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define MTS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent checked in the same cycle as the antecedent
`define MTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mts_pkg.sv
// shared types and codes of the min tracking stack
// no dependencies; used by the channel interfaces and the top level
package mts_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned STATUS_W  = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [COUNT_W-1:0]       count_t;
	typedef logic [CMD_W-1:0]         cmd_t;
	typedef logic [STATUS_W-1:0]      status_t;

	typedef struct packed {
		data_t   top_value;
		data_t   min_value;
		count_t  entry_count;
		status_t status;
	} result_t;

endpackage

FILE: src/mts_cmd_if.sv
// command channel of the min tracking stack: valid, ready and one command
// depends on mts_pkg
interface mts_cmd_if;
	logic            valid;
	logic            ready;
	mts_pkg::cmd_t   command;
	mts_pkg::data_t  push_value;

	modport source (output valid, output command, output push_value, input ready);
	modport sink (input valid, input command, input push_value, output ready);
endinterface

FILE: src/mts_res_if.sv
// result channel of the min tracking stack: valid, ready and one result
// depends on mts_pkg
interface mts_res_if;
	logic              valid;
	logic              ready;
	mts_pkg::data_t    top_value;
	mts_pkg::data_t    min_value;
	mts_pkg::count_t   entry_count;
	mts_pkg::status_t  status;

	modport source (output valid, output top_value, output min_value, output entry_count,
		output status, input ready);
	modport sink (input valid, input top_value, input min_value, input entry_count,
		input status, output ready);
endinterface

FILE: src/min_tracking_stack.sv
// min tracking stack: lifo of signed values that also reports the smallest value held
// depends on mts_pkg, mts_cmd_if, mts_res_if and min_tracking_stack_macros.svh
//
// usage:
//   cmd carries one command per transaction (push, pop, read; code 3 acts as read).
//   result returns exactly one transaction per command: top value, minimum,
//   entry count and status, in command order.
// result path:
//   push, read, refused commands and a pop that empties the stack register their
//   result straight into the result queue. a pop that exposes a lower entry passes
//   through the registered read of the value and minimum memories and the
//   S_POP_WAIT state before its result enters the queue.
//   one command per cycle while the holding register is empty, except a pop that
//   exposes a lower entry: cmd.ready stays low while the memory read completes.
// reset:
//   arst_n clears the entry count and the result registers; no clearing pass,
//   memory entries are only read once written by a push.
// stall:
//   a result register plus one holding register sit before the result port, so
//   one more command is taken while a result waits; after that cmd.ready drops
//   until the receiver takes a result.
`include "min_tracking_stack_macros.svh"

module min_tracking_stack #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	mts_cmd_if.sink     cmd,
	mts_res_if.source   result
);

	localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_POP_WAIT
	} state_t;

	function automatic mts_pkg::count_t to_count(logic [CNT_W-1:0] x);
		logic [CNT_W+mts_pkg::COUNT_W-1:0] e;
		e = {{mts_pkg::COUNT_W{1'b0}}, x};
		return e[mts_pkg::COUNT_W-1:0];
	endfunction

	// value and minimum memories, one entry per stack slot
	mts_pkg::data_t value_mem [STACK_DEPTH];
	mts_pkg::data_t min_mem [STACK_DEPTH];

	state_t             state_q;
	logic [CNT_W-1:0]   fill_q;
	mts_pkg::data_t     top_val_q;
	mts_pkg::data_t     top_min_q;
	mts_pkg::data_t     rd_val_q;
	mts_pkg::data_t     rd_min_q;
	mts_pkg::result_t   out_q;
	logic               out_valid_q;
	mts_pkg::result_t   hold_q;
	logic               hold_valid_q;

	logic               accept;
	logic               is_empty;
	logic               is_full;
	logic [CNT_W-1:0]   fill_inc;
	logic [CNT_W-1:0]   fill_dec;
	logic [CNT_W-1:0]   fill_m2;
	mts_pkg::data_t     show_top;
	mts_pkg::data_t     show_min;
	mts_pkg::data_t     push_min;
	logic               mem_we;
	logic [IDX_W-1:0]   wr_addr;
	logic               mem_re;
	logic [IDX_W-1:0]   rd_addr;
	logic               res_fire;
	mts_pkg::result_t   res;
	state_t             state_d;
	logic [CNT_W-1:0]   fill_d;
	logic               cache_we;
	mts_pkg::data_t     cache_val;
	mts_pkg::data_t     cache_min;
	logic               out_pop;

	assign cmd.ready = (state_q == S_IDLE) && !hold_valid_q;
	assign accept    = cmd.valid && cmd.ready;
	assign is_empty  = (fill_q == '0);
	assign is_full   = (fill_q == CNT_W'(STACK_DEPTH));
	assign fill_inc  = fill_q + CNT_W'(1);
	assign fill_dec  = fill_q - CNT_W'(1);
	assign fill_m2   = fill_q - CNT_W'(2);
	assign show_top  = is_empty ? '0 : top_val_q;
	assign show_min  = is_empty ? '0 : top_min_q;
	assign push_min  = (!is_empty && !(cmd.push_value < top_min_q)) ? top_min_q
		: cmd.push_value;

	assign wr_addr = fill_q[IDX_W-1:0];
	assign rd_addr = fill_m2[IDX_W-1:0];

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		cache_we  = 1'b0;
		cache_val = rd_val_q;
		cache_min = rd_min_q;
		res_fire  = 1'b0;
		res       = '{top_value: show_top, min_value: show_min,
			entry_count: to_count(fill_q), status: mts_pkg::STATUS_OK};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.command)
						mts_pkg::CMD_PUSH: begin
							res_fire = 1'b1;
							if (is_full) begin
								res.status = mts_pkg::STATUS_FULL;
							end else begin
								mem_we    = 1'b1;
								cache_we  = 1'b1;
								cache_val = cmd.push_value;
								cache_min = push_min;
								fill_d    = fill_inc;
								res = '{top_value: cmd.push_value, min_value: push_min,
									entry_count: to_count(fill_inc),
									status: mts_pkg::STATUS_OK};
							end
						end
						mts_pkg::CMD_POP: begin
							if (is_empty) begin
								res_fire   = 1'b1;
								res.status = mts_pkg::STATUS_EMPTY;
							end else if (fill_q == CNT_W'(1)) begin
								// stack becomes empty, nothing to fetch
								res_fire = 1'b1;
								fill_d   = fill_dec;
								res = '{top_value: '0, min_value: '0,
									entry_count: to_count(fill_dec),
									status: mts_pkg::STATUS_OK};
							end else begin
								mem_re  = 1'b1;
								fill_d  = fill_dec;
								state_d = S_POP_WAIT;
							end
						end
						default: begin
							res_fire = 1'b1;
							if (is_empty) begin
								res.status = mts_pkg::STATUS_EMPTY;
							end
						end
					endcase
				end
			end
			S_POP_WAIT: begin
				// new top arrives from the registered memory read
				cache_we = 1'b1;
				res_fire = 1'b1;
				state_d  = S_IDLE;
				res = '{top_value: rd_val_q, min_value: rd_min_q,
					entry_count: to_count(fill_q), status: mts_pkg::STATUS_OK};
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			value_mem[wr_addr] <= cmd.push_value;
			min_mem[wr_addr]   <= push_min;
		end
		if (mem_re) begin
			rd_val_q <= value_mem[rd_addr];
			rd_min_q <= min_mem[rd_addr];
		end
	end

	assign out_pop = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			top_val_q    <= '0;
			top_min_q    <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			hold_q       <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (cache_we) begin
				top_val_q <= cache_val;
				top_min_q <= cache_min;
			end
			// two-entry result queue: out_q drives the port, hold_q backs it up
			if (out_pop || !out_valid_q) begin
				if (hold_valid_q) begin
					out_q       <= hold_q;
					out_valid_q <= 1'b1;
					if (res_fire) begin
						hold_q <= res;
					end else begin
						hold_valid_q <= 1'b0;
					end
				end else if (res_fire) begin
					out_q       <= res;
					out_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b0;
				end
			end else if (res_fire) begin
				hold_q       <= res;
				hold_valid_q <= 1'b1;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.top_value   = out_q.top_value;
	assign result.min_value   = out_q.min_value;
	assign result.entry_count = out_q.entry_count;
	assign result.status      = out_q.status;

	`MTS_ASSERT_ALWAYS(a_fill_range, clk, arst_n, fill_q <= CNT_W'(STACK_DEPTH), "fill level above stack depth")
	`MTS_ASSERT_SAME(a_hold_behind_out, clk, arst_n, hold_valid_q, out_valid_q, "holding register valid while output register empty")
	`MTS_ASSERT_SAME(a_no_result_overflow, clk, arst_n, res_fire && hold_valid_q, out_pop, "result produced with no room in the result queue")
	`MTS_ASSERT_NEXT(a_read_answers, clk, arst_n, accept && cmd.command != mts_pkg::CMD_POP, out_valid_q && state_q == S_IDLE, "push or read gave no result in the next cycle")

endmodule
